@@ src/lr_pkg.sv @@
`default_nettype none
package lr_pkg;

    // coordinate width used by the stepping logic; field widths stay fixed
    localparam int COORD_BITS = 6;
    localparam int FIELD_BITS = 6;
    localparam int COLOR_BITS = 8;
    // error term: spans -2*major .. 2*minor plus headroom, signed
    localparam int ERR_BITS   = COORD_BITS + 3;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic signed [ERR_BITS-1:0] t_err;

    typedef struct packed {
        logic [FIELD_BITS-1:0] start_x;
        logic [FIELD_BITS-1:0] start_y;
        logic [FIELD_BITS-1:0] end_x;
        logic [FIELD_BITS-1:0] end_y;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] pixel_x;
        logic [FIELD_BITS-1:0] pixel_y;
        logic [COLOR_BITS-1:0] pixel_red;
        logic [COLOR_BITS-1:0] pixel_green;
        logic [COLOR_BITS-1:0] pixel_blue;
        logic                  last_pixel;
    } t_out_item;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;   // capture a new command and set up the walk
        logic step;   // advance to the next pixel
    } t_dp_cmd;

    typedef struct packed {
        logic last;   // current pixel is the final one of the line
    } t_dp_stat;

endpackage
`default_nettype wire

@@ src/lr_ctrl.sv @@
`default_nettype none
module lr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire lr_pkg::t_dp_stat i_stat,
    output lr_pkg::t_dp_cmd       o_cmd
);
    import lr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                // no command beat while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ src/lr_datapath.sv @@
`default_nettype none
module lr_datapath (
    input  wire logic             i_clk,
    input  wire lr_pkg::t_dp_cmd  i_cmd,
    input  wire lr_pkg::t_in_item i_item,
    output lr_pkg::t_dp_stat      o_stat,
    output lr_pkg::t_out_item     o_pixel
);
    import lr_pkg::*;

    t_coord x1, y1, x2, y2;
    t_coord adx, ady;
    logic   shallow, swap_ends, dec0;
    t_coord px, py, qx, qy;
    t_coord a0, b0, b_end, major0, minor0;
    t_err   err0;

    t_coord r_a, r_b, r_cnt, r_major, r_minor;
    t_err   r_err;
    logic   r_steep, r_dec;
    logic [COLOR_BITS-1:0] r_red, r_green, r_blue;
    t_err   major2, minor2;

    // setup: order endpoints along the major axis
    always_comb begin
        x1 = i_item.start_x[COORD_BITS-1:0];
        y1 = i_item.start_y[COORD_BITS-1:0];
        x2 = i_item.end_x[COORD_BITS-1:0];
        y2 = i_item.end_y[COORD_BITS-1:0];
        adx = (x2 > x1) ? x2 - x1 : x1 - x2;
        ady = (y2 > y1) ? y2 - y1 : y1 - y2;
        shallow   = ady < adx;
        swap_ends = shallow ? (x1 > x2) : (y1 > y2);
        px = swap_ends ? x2 : x1;
        py = swap_ends ? y2 : y1;
        qx = swap_ends ? x1 : x2;
        qy = swap_ends ? y1 : y2;
        a0     = shallow ? px : py;
        b0     = shallow ? py : px;
        b_end  = shallow ? qy : qx;
        major0 = shallow ? adx : ady;
        minor0 = shallow ? ady : adx;
        dec0   = b_end < b0;
        err0   = (t_err'(minor0) <<< 1) - t_err'(major0);
    end

    assign major2 = t_err'(r_major) <<< 1;
    assign minor2 = t_err'(r_minor) <<< 1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= a0;
            r_b     <= b0;
            r_cnt   <= major0;
            r_major <= major0;
            r_minor <= minor0;
            r_err   <= err0;
            r_steep <= !shallow;
            r_dec   <= dec0;
            r_red   <= i_item.red;
            r_green <= i_item.green;
            r_blue  <= i_item.blue;
        end else if (i_cmd.step) begin
            r_a   <= r_a + t_coord'(1);
            r_cnt <= r_cnt - t_coord'(1);
            if (r_err > 0) begin
                r_b   <= r_dec ? r_b - t_coord'(1) : r_b + t_coord'(1);
                r_err <= r_err - major2 + minor2;
            end else begin
                r_err <= r_err + minor2;
            end
        end
    end

    assign o_stat.last = (r_cnt == '0);

    always_comb begin
        o_pixel.pixel_x     = FIELD_BITS'(r_steep ? r_b : r_a);
        o_pixel.pixel_y     = FIELD_BITS'(r_steep ? r_a : r_b);
        o_pixel.pixel_red   = r_red;
        o_pixel.pixel_green = r_green;
        o_pixel.pixel_blue  = r_blue;
        o_pixel.last_pixel  = o_stat.last;
    end

endmodule
`default_nettype wire

@@ src/line_rasterizer_core.sv @@
// First pixel: offered in the cycle after the command beat is taken.
// Pixels: a line of N pixels (N = major axis length + 1, up to 64) is set up
//   when its command beat is taken, then offered one pixel a cycle while the
//   output does not stall, from the datapath's single error-term update loop.
// Reset: synchronous active-low i_rst_n returns the controller to idle; the
//   datapath registers hold payload only and are not reset.
`default_nettype none
module line_rasterizer_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire lr_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output lr_pkg::t_out_item      o_out_data
);
    import lr_pkg::*;

    // command/status between controller and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // controller: idle takes a command beat, run offers pixels until last
    lr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // datapath: endpoint ordering, error term, pixel counter, output fields.
    // The pixel registers double as the output register, so a stalled
    // pixel simply holds until its beat completes.
    lr_datapath u_dp (
        .i_clk   (i_clk),
        .i_cmd   (dp_cmd),
        .i_item  (i_in_data),
        .o_stat  (dp_stat),
        .o_pixel (o_out_data)
    );

    // one line at a time: never take a command while pixels are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("command accepted while line in progress");

    // a taken command always yields a pixel on the next cycle
    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> o_out_valid)
        else $error("no pixel after command beat");

    // last pixel ends the line
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_pixel) |=>
        (!o_out_valid && o_in_ready))
        else $error("line did not end after last pixel");

    // non-last pixel beat keeps the line going
    a_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_pixel) |=> o_out_valid)
        else $error("line stopped before last pixel");

endmodule
`default_nettype wire
